// ===== sv/gcos_pkg.sv =====
// Package for the grouped charge order statistics core.
// Holds payload, command and status types, sizes, sentinels and group tables.
// Used by every module of the block but gcos_ram; depends on nothing.
`timescale 1ns / 1ps
package gcos_pkg;

   localparam int MAX_HITS  = 64;
   localparam int IDX_W     = $clog2(MAX_HITS);
   localparam int CNT_W     = $clog2(MAX_HITS + 1);
   localparam int NUM_GRP   = 5;
   localparam int NUM_SLOT  = 22;
   localparam int SLOT_W    = 5;
   localparam int HIT_W     = 31;
   localparam int FIFO_DEPTH = 2;

   localparam logic [24:0] SENT_MED = 25'd3199968;
   localparam logic [24:0] SENT_LOW = 25'd31999968;

   localparam logic ACT_HIT = 1'b0;
   localparam logic ACT_END = 1'b1;
   localparam logic KIND_ORDER = 1'b0;
   localparam logic KIND_LAYER = 1'b1;
   localparam logic [2:0] LAST_GROUP = 3'd4;

   typedef struct packed {
      logic        action;
      logic [2:0]  subdetector;
      logic [3:0]  layer_number;
      logic [23:0] charge;
      logic [23:0] fit_estimate;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  group;
      logic [3:0]  layer_index;
      logic [24:0] median_value;
      logic [24:0] value_0;
      logic [24:0] value_1;
      logic [24:0] value_2;
      logic [24:0] value_3;
      logic [24:0] value_4;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        is_end;
      logic [2:0]  det;
      logic [3:0]  lay;
      logic [23:0] q;
   } cmd_type;

   // One stored hit; HIT_W bits wide.
   typedef struct packed {
      logic [2:0]  det;
      logic [3:0]  lay;
      logic [23:0] q;
   } hit_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] hit_count;
   } status_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] idx;
   } slot_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_GRP_INIT,
      BK_OUTER_RD,
      BK_OUTER_LAT,
      BK_INNER,
      BK_EMIT_OS,
      BK_EMIT_LAY
   } back_state_type;

   function automatic logic [2:0] grp_code(input logic [2:0] g);
      logic [2:0] c;
      unique case (g)
         3'd1:    c = 3'd3;
         3'd2:    c = 3'd4;
         3'd3:    c = 3'd5;
         3'd4:    c = 3'd6;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] grp_lays(input logic [2:0] g);
      logic [3:0] n;
      unique case (g)
         3'd1:    n = 4'd4;
         3'd2:    n = 4'd3;
         3'd3:    n = 4'd6;
         3'd4:    n = 4'd9;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [SLOT_W-1:0] grp_base(input logic [2:0] g);
      logic [SLOT_W-1:0] b;
      unique case (g)
         3'd2:    b = 5'd4;
         3'd3:    b = 5'd7;
         3'd4:    b = 5'd13;
         default: b = 5'd0;
      endcase
      return b;
   endfunction

   // Map a subdetector code to its group index; zero for unused codes.
   function automatic logic [2:0] det_group(input logic [2:0] det);
      logic [2:0] g;
      unique case (det)
         3'd3:    g = 3'd1;
         3'd4:    g = 3'd2;
         3'd5:    g = 3'd3;
         3'd6:    g = 3'd4;
         default: g = 3'd0;
      endcase
      return g;
   endfunction

   function automatic slot_type layer_slot(input logic [2:0] det, input logic [3:0] lay);
      slot_type   s;
      logic [2:0] g;
      g     = det_group(det);
      s.hit = (g != 3'd0) && (lay != 4'd0) && (lay <= grp_lays(g));
      s.idx = grp_base(g) + SLOT_W'(lay) - 5'd1;
      return s;
   endfunction

endpackage

// ===== sv/gcos_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gcos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/gcos_front.sv =====
// Front end: holds the estimate cut, filters hits and forms commands.
// Depends on gcos_pkg.
`timescale 1ns / 1ps
module gcos_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [23:0]      csr_wdata,
   input  logic             push,
   input  gcos_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output gcos_pkg::cmd_type q_cmd
);
   import gcos_pkg::*;

   logic [23:0] cut_ff, cut_in;

   always_comb begin
      cut_in = csr_we ? csr_wdata : cut_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff <= 24'hFFFFFF;
      end else begin
         cut_ff <= cut_in;
      end
   end

   // Drop hits that fail the cut; end of track always passes.
   always_comb begin
      q_cmd.is_end = (req_data.action == ACT_END);
      q_cmd.det    = req_data.subdetector;
      q_cmd.lay    = req_data.layer_number;
      q_cmd.q      = req_data.charge;
      q_push = push && !q_full &&
               (q_cmd.is_end || (req_data.fit_estimate < cut_ff));
   end
endmodule

// ===== sv/gcos_fifo.sv =====
// Short command queue between front and back.
// Depends on gcos_pkg.
`timescale 1ns / 1ps
module gcos_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  gcos_pkg::cmd_type wr_data,
   input  logic              rd_en,
   output gcos_pkg::cmd_type rd_data,
   output logic              full,
   output logic              empty
);
   import gcos_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

   cmd_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             do_wr, do_rd;

   assign full  = (occ_ff == OCC_W'(FIFO_DEPTH));
   assign empty = (occ_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = do_wr ? ((wptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_ff + 1'b1) : wptr_ff;
      rptr_in = do_rd ? ((rptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_ff + 1'b1) : rptr_ff;
      occ_in  = occ_ff + OCC_W'(do_wr) - OCC_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         occ_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         occ_ff  <= occ_in;
      end
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end
endmodule

// ===== sv/gcos_back.sv =====
// Back end: stores hits, keeps layer ranges and group counts, ranks hits
// per group at end of track and drives the result register.
// Depends on gcos_pkg and gcos_ram.
`timescale 1ns / 1ps
module gcos_back (
   input  logic                 clock,
   input  logic                 reset,
   input  gcos_pkg::cmd_type    cmd,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   input  logic                 pop,
   output logic                 empty,
   output gcos_pkg::rsp_type    rsp_data,
   output gcos_pkg::status_type status
);
   import gcos_pkg::*;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  gcnt_ff [NUM_GRP];
   logic              ovf_ff;
   logic [24:0]       lmin_ff [NUM_SLOT];
   logic [24:0]       lmax_ff [NUM_SLOT];
   logic [NUM_SLOT-1:0] lval_ff;
   logic [2:0]        g_ff;
   logic [3:0]        lay_ff;
   logic [CNT_W-1:0]  i_ff, j_ff, rank_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  pj_ff;
   logic [23:0]       qi_ff;
   logic [24:0]       v_ff [5];
   logic [24:0]       med_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_raddr;
   hit_type           ram_wdata, ram_rdata;

   logic              out_free, rsp_load, load_hit, room;
   logic              member_rd, inner_done, lay_done;
   logic [CNT_W-1:0]  n_g, lo_idx, hi_idx;
   slot_type          slot;
   logic [SLOT_W-1:0] out_slot;
   logic [24:0]       x2;

   gcos_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff[IDX_W-1:0]),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ram_wdata  = {cmd.det, cmd.lay, cmd.q};
   assign out_free   = !rsp_valid_ff || pop;
   assign room       = (cnt_ff < CNT_W'(MAX_HITS));
   assign n_g        = gcnt_ff[g_ff];
   assign lo_idx     = (n_g - 1'b1) >> 1;
   assign hi_idx     = n_g >> 1;
   assign member_rd  = (g_ff == 3'd0) || (ram_rdata.det == grp_code(g_ff));
   assign inner_done = (j_ff == cnt_ff) && !pend_ff;
   assign lay_done   = (lay_ff == grp_lays(g_ff));
   assign slot       = layer_slot(cmd.det, cmd.lay);
   assign out_slot   = grp_base(g_ff) + SLOT_W'(lay_ff) - 5'd1;
   assign x2         = {cmd.q, 1'b0};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:      if (!cmd_empty && cmd.is_end) state_in = BK_GRP_INIT;
         BK_GRP_INIT:  state_in = BK_OUTER_RD;
         BK_OUTER_RD:  state_in = (i_ff == cnt_ff) ? BK_EMIT_OS : BK_OUTER_LAT;
         BK_OUTER_LAT: state_in = member_rd ? BK_INNER : BK_OUTER_RD;
         BK_INNER:     if (inner_done) state_in = BK_OUTER_RD;
         BK_EMIT_OS: begin
            if (out_free) begin
               state_in = (grp_lays(g_ff) == 4'd0) ? BK_GRP_INIT : BK_EMIT_LAY;
            end
         end
         BK_EMIT_LAY: begin
            if (out_free && lay_done) begin
               state_in = (g_ff == LAST_GROUP) ? BK_IDLE : BK_GRP_INIT;
            end
         end
         default:      state_in = BK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      cmd_pop   = 1'b0;
      load_hit  = 1'b0;
      ram_we    = 1'b0;
      rsp_load  = 1'b0;
      ram_raddr = i_ff[IDX_W-1:0];
      rsp_in    = rsp_ff;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_pop  = !cmd_empty;
            load_hit = !cmd_empty && !cmd.is_end;
            ram_we   = load_hit && room;
         end
         BK_INNER: ram_raddr = j_ff[IDX_W-1:0];
         BK_EMIT_OS: begin
            rsp_load            = out_free;
            rsp_in.kind         = KIND_ORDER;
            rsp_in.group        = g_ff;
            rsp_in.layer_index  = 4'd0;
            rsp_in.median_value = (n_g == '0) ? SENT_MED : med_ff;
            rsp_in.value_0      = v_ff[0];
            rsp_in.value_1      = v_ff[1];
            rsp_in.value_2      = v_ff[2];
            rsp_in.value_3      = v_ff[3];
            rsp_in.value_4      = v_ff[4];
            rsp_in.overflow     = ovf_ff;
            rsp_in.last         = 1'b0;
         end
         BK_EMIT_LAY: begin
            rsp_load            = out_free;
            rsp_in.kind         = KIND_LAYER;
            rsp_in.group        = g_ff;
            rsp_in.layer_index  = lay_ff;
            rsp_in.median_value = '0;
            rsp_in.value_0      = lval_ff[out_slot] ? lmin_ff[out_slot] : SENT_MED;
            rsp_in.value_1      = lval_ff[out_slot] ? lmax_ff[out_slot] : SENT_MED;
            rsp_in.value_2      = '0;
            rsp_in.value_3      = '0;
            rsp_in.value_4      = '0;
            rsp_in.overflow     = ovf_ff;
            rsp_in.last         = (g_ff == LAST_GROUP) && lay_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         lval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         for (int k = 0; k < NUM_GRP; k++) gcnt_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load_hit) begin
            if (room) begin
               cnt_ff     <= cnt_ff + 1'b1;
               gcnt_ff[0] <= gcnt_ff[0] + 1'b1;
               if (det_group(cmd.det) != 3'd0) begin
                  gcnt_ff[det_group(cmd.det)] <= gcnt_ff[det_group(cmd.det)] + 1'b1;
               end
               if (slot.hit) begin
                  lval_ff[slot.idx] <= 1'b1;
               end
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (state_ff == BK_INNER) begin
            pend_ff <= (j_ff != cnt_ff);
         end else begin
            pend_ff <= 1'b0;
         end
         // Clear the track after its final result.
         if (state_ff == BK_EMIT_LAY && out_free && lay_done && g_ff == LAST_GROUP) begin
            cnt_ff  <= '0;
            ovf_ff  <= 1'b0;
            lval_ff <= '0;
            for (int k = 0; k < NUM_GRP; k++) gcnt_ff[k] <= '0;
         end
      end

      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end

      // Layer range update.
      if (load_hit && room && slot.hit) begin
         if (!lval_ff[slot.idx] || x2 < lmin_ff[slot.idx]) lmin_ff[slot.idx] <= x2;
         if (!lval_ff[slot.idx] || x2 > lmax_ff[slot.idx]) lmax_ff[slot.idx] <= x2;
      end

      unique case (state_ff)
         BK_IDLE: g_ff <= 3'd0;
         BK_GRP_INIT: begin
            i_ff   <= '0;
            med_ff <= '0;
            for (int k = 0; k < 5; k++) v_ff[k] <= SENT_LOW;
         end
         BK_OUTER_LAT: begin
            qi_ff   <= ram_rdata.q;
            rank_ff <= '0;
            j_ff    <= '0;
            if (!member_rd) i_ff <= i_ff + 1'b1;
         end
         BK_INNER: begin
            if (j_ff != cnt_ff) begin
               pj_ff <= j_ff[IDX_W-1:0];
               j_ff  <= j_ff + 1'b1;
            end
            // Rank with ties broken by store position.
            if (pend_ff && member_rd &&
                ((ram_rdata.q < qi_ff) ||
                 (ram_rdata.q == qi_ff && CNT_W'(pj_ff) < i_ff))) begin
               rank_ff <= rank_ff + 1'b1;
            end
            if (inner_done) begin
               i_ff <= i_ff + 1'b1;
               if (rank_ff < CNT_W'(5)) v_ff[rank_ff[2:0]] <= {qi_ff, 1'b0};
               med_ff <= med_ff + ((rank_ff == lo_idx) ? 25'(qi_ff) : 25'd0)
                                + ((rank_ff == hi_idx) ? 25'(qi_ff) : 25'd0);
            end
         end
         BK_EMIT_OS: begin
            if (out_free) begin
               if (grp_lays(g_ff) == 4'd0) g_ff <= g_ff + 1'b1;
               else lay_ff <= 4'd1;
            end
         end
         BK_EMIT_LAY: begin
            if (out_free) begin
               if (lay_done) g_ff <= g_ff + 1'b1;
               else lay_ff <= lay_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign status.busy      = (state_ff != BK_IDLE);
   assign status.hit_count = cnt_ff;
endmodule

// ===== sv/grouped_charge_order_statistics_core.sv =====
// Top level of the grouped charge order statistics core.
// Depends on gcos_pkg, gcos_front, gcos_fifo and gcos_back.
`timescale 1ns / 1ps
// The core collects the hits of one track and, on an end-of-track
// transaction, returns 27 results: for all hits and for each of subdetector
// codes 3..6 the median and five smallest charges, then the minimum and
// maximum charge of every layer of that subdetector. Hits whose fit estimate
// is not below csr_wdata's cut are dropped; kept hits beyond 64 are dropped
// and flagged in overflow. Hits pass the combinational front and the
// two-entry command queue into the back, which loads one hit per cycle
// while it is idle. End-of-track work is paced by the ranking loop, which
// reads the hit store through its single read port, and then by how fast
// the receiver takes the results. No new transaction is taken from the
// queue until the final result has been loaded.
module grouped_charge_order_statistics_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [23:0]       csr_wdata,
   input  logic              push,
   output logic              full,
   input  gcos_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output gcos_pkg::rsp_type rsp_data
);
   import gcos_pkg::*;

   cmd_type    q_in_cmd, q_out_cmd;
   logic       q_push, q_pop, q_empty;
   status_type status;

   // Filter and classify incoming transactions.
   gcos_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .req_data  (req_data),
      .q_full    (full),
      .q_push    (q_push),
      .q_cmd     (q_in_cmd)
   );

   // Decouple the front from the back.
   gcos_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_in_cmd),
      .rd_en   (q_pop),
      .rd_data (q_out_cmd),
      .full    (full),
      .empty   (q_empty)
   );

   // Store hits and produce the results.
   gcos_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_out_cmd),
      .cmd_empty (q_empty),
      .cmd_pop   (q_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // Store never holds more than its capacity.
   a_cap: assert property (@(posedge clock) disable iff (reset)
      status.hit_count <= CNT_W'(MAX_HITS))
      else $error("hit count beyond capacity");

   // Final result is the last layer of the last group.
   a_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last) |->
         (rsp_data.kind == KIND_LAYER && rsp_data.group == LAST_GROUP &&
          rsp_data.layer_index == 4'd9))
      else $error("last flag on wrong result");

   // Order statistic results carry no layer.
   a_os_layer: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind == KIND_ORDER) |-> (rsp_data.layer_index == 4'd0))
      else $error("layer index on order statistic result");

   // Store is empty once the track's results are all loaded.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last && $rose(!empty)) |-> (status.hit_count == '0))
      else $error("store not cleared after track");
endmodule

// ===== tb/grouped_charge_order_statistics_core_tb.sv =====
// Testbench for the grouped charge order statistics core.
// Drives hit and end-of-track transactions, predicts the 27 results per track
// and checks them in order. Depends on gcos_pkg and the core.
`timescale 1ns / 1ps

// Scoreboard: holds the predicted track results and the core's own state copy.
class charge_stats_board;
   gcos_pkg::rsp_type track_results[$];
   logic [2:0]  hit_det[$];
   logic [3:0]  hit_lay[$];
   logic [23:0] hit_q[$];
   logic        dropped;
   logic [23:0] cut;
   int          mismatches;

   function new();
      cut = 24'hFFFFFF;
      dropped = 1'b0;
      mismatches = 0;
   endfunction

   function automatic logic [2:0] code_of(int g);
      logic [2:0] codes [5];
      codes = '{3'd0, 3'd3, 3'd4, 3'd5, 3'd6};
      return codes[g];
   endfunction

   function automatic int layers_of(int g);
      int lays [5];
      lays = '{0, 4, 3, 6, 9};
      return lays[g];
   endfunction

   // Note an accepted input transaction and predict its results.
   function void note_request(gcos_pkg::req_type r);
      logic [23:0] ranked[$];
      gcos_pkg::rsp_type o;
      logic [24:0] lo, hi, x;
      int n, count;
      bit found;
      if (r.action == gcos_pkg::ACT_HIT) begin
         if (r.fit_estimate < cut) begin
            if (hit_q.size() < gcos_pkg::MAX_HITS) begin
               hit_det.insert(hit_det.size(), r.subdetector);
               hit_lay.insert(hit_lay.size(), r.layer_number);
               hit_q.insert(hit_q.size(), r.charge);
            end else begin
               dropped = 1'b1;
            end
         end
         return;
      end
      count = 0;
      for (int g = 0; g < 5; g++) begin
         ranked.delete();
         foreach (hit_q[i])
            if (g == 0 || hit_det[i] == code_of(g)) ranked.insert(ranked.size(), hit_q[i]);
         ranked.sort();
         n = ranked.size();
         o = '0;
         o.kind = gcos_pkg::KIND_ORDER;
         o.group = 3'(g);
         if (n == 0) o.median_value = gcos_pkg::SENT_MED;
         else if (n % 2) o.median_value = {ranked[(n - 1) / 2], 1'b0};
         else o.median_value = 25'(ranked[n / 2 - 1]) + 25'(ranked[n / 2]);
         o.value_0 = (n > 0) ? {ranked[0], 1'b0} : gcos_pkg::SENT_LOW;
         o.value_1 = (n > 1) ? {ranked[1], 1'b0} : gcos_pkg::SENT_LOW;
         o.value_2 = (n > 2) ? {ranked[2], 1'b0} : gcos_pkg::SENT_LOW;
         o.value_3 = (n > 3) ? {ranked[3], 1'b0} : gcos_pkg::SENT_LOW;
         o.value_4 = (n > 4) ? {ranked[4], 1'b0} : gcos_pkg::SENT_LOW;
         o.overflow = dropped;
         count++;
         o.last = (count == 27);
         track_results.insert(track_results.size(), o);
         for (int lay = 1; lay <= layers_of(g); lay++) begin
            found = 0;
            lo = gcos_pkg::SENT_MED;
            hi = gcos_pkg::SENT_MED;
            foreach (hit_q[i])
               if (hit_det[i] == code_of(g) && hit_lay[i] == 4'(lay)) begin
                  x = {hit_q[i], 1'b0};
                  if (!found) begin
                     lo = x;
                     hi = x;
                     found = 1;
                  end else begin
                     if (x < lo) lo = x;
                     if (x > hi) hi = x;
                  end
               end
            o = '0;
            o.kind = gcos_pkg::KIND_LAYER;
            o.group = 3'(g);
            o.layer_index = 4'(lay);
            o.value_0 = lo;
            o.value_1 = hi;
            o.overflow = dropped;
            count++;
            o.last = (count == 27);
            track_results.insert(track_results.size(), o);
         end
      end
      hit_det.delete();
      hit_lay.delete();
      hit_q.delete();
      dropped = 1'b0;
   endfunction

   task report_mismatch(string what, gcos_pkg::rsp_type want,
                        gcos_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch %s: want %h got %h", what, want, got);
   endtask

   // Compare one accepted result with the oldest prediction.
   task check_result(gcos_pkg::rsp_type got);
      gcos_pkg::rsp_type want;
      if (track_results.size() == 0) begin
         report_mismatch("result with nothing expected", '0, got);
         return;
      end
      want = track_results.pop_front();
      if (got.kind != want.kind) report_mismatch("kind", want, got);
      if (got.group != want.group) report_mismatch("group", want, got);
      if (got.layer_index != want.layer_index) report_mismatch("layer_index", want, got);
      if (got.median_value != want.median_value) report_mismatch("median_value", want, got);
      if (got.value_0 != want.value_0) report_mismatch("value_0", want, got);
      if (got.value_1 != want.value_1) report_mismatch("value_1", want, got);
      if (got.value_2 != want.value_2) report_mismatch("value_2", want, got);
      if (got.value_3 != want.value_3) report_mismatch("value_3", want, got);
      if (got.value_4 != want.value_4) report_mismatch("value_4", want, got);
      if (got.overflow != want.overflow) report_mismatch("overflow", want, got);
      if (got.last != want.last) report_mismatch("last", want, got);
   endtask
endclass

module grouped_charge_order_statistics_core_tb;
   import gcos_pkg::*;

   localparam int STALL_LIMIT = 50000;

   logic    clock;
   logic    reset;
   logic    csr_we;
   logic [23:0] csr_wdata;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   charge_stats_board board;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  recv_hold;
   int  quiet_cycles;
   bit  timed_out;

   grouped_charge_order_statistics_core uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both handshakes at the rising edge; feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) board.note_request(req_data);
         if (pop && !empty) board.check_result(rsp_data);
         if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: end the run when nothing is accepted for too long.
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("grouped_charge_order_statistics_core_tb: FAIL");
         $finish;
      end
   end

   // Receiver: change pop at the falling edge; hold off while recv_hold is set.
   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one transaction, with a random gap first, and wait for acceptance.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_data = r;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic send_hit(logic [2:0] det, logic [3:0] lay, logic [23:0] q,
                           logic [23:0] est);
      req_type r;
      r.action = ACT_HIT;
      r.subdetector = det;
      r.layer_number = lay;
      r.charge = q;
      r.fit_estimate = est;
      send_request(r);
   endtask

   // End of track carries random junk in the ignored fields.
   task automatic send_end();
      req_type r;
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      r = junk[$bits(req_type)-1:0];
      r.action = ACT_END;
      send_request(r);
   endtask

   // Wait until all predicted results arrived, then let the core settle.
   task automatic drain();
      while (board.track_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_cut(logic [23:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      board.cut = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random track: mostly real subdetectors and listed layers, some noise.
   task automatic random_track(int hits);
      logic [2:0] det;
      logic [3:0] lay;
      for (int i = 0; i < hits; i++) begin
         det = ($urandom_range(9) < 8) ? 3'($urandom_range(6, 3)) : 3'($urandom);
         lay = ($urandom_range(9) < 8) ? 4'($urandom_range(9, 1)) : 4'($urandom);
         send_hit(det, lay,
                  ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(4000)),
                  ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(2000)));
      end
      send_end();
   endtask

   initial begin
      board = new();
      quiet_cycles = 0;
      timed_out = 0;
      recv_hold = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty track, extremes, every group, odd and even medians.
      send_end();
      send_hit(3'd3, 4'd1, 24'hFFFFFF, 24'hFFFFFE);
      send_hit(3'd3, 4'd4, 24'd0, 24'd0);
      send_hit(3'd4, 4'd3, 24'd10, 24'd5);
      send_hit(3'd5, 4'd6, 24'd7, 24'd5);
      send_hit(3'd6, 4'd9, 24'hAAAAAA, 24'h555555);
      send_hit(3'd6, 4'd9, 24'h555555, 24'hAAAAAA);
      send_hit(3'd0, 4'd15, 24'd3, 24'd1);
      send_hit(3'd7, 4'd0, 24'd4, 24'd1);
      send_hit(3'd6, 4'd10, 24'd9, 24'd1);
      send_hit(3'd4, 4'd4, 24'd2, 24'd1);
      send_hit(3'd6, 4'd1, 24'd5, 24'hFFFFFF); // at the reset cut: dropped
      send_end();
      drain();

      // Cut of zero drops every hit.
      write_cut(24'd0);
      send_hit(3'd3, 4'd1, 24'd100, 24'd0);
      send_end();
      drain();
      write_cut(24'd1000);

      // Long tracks: 70 hits offered, more than the store holds, though the cut drops some; with a full receiver stall.
      fork
         begin
            recv_hold = 1;
            repeat (400) @(negedge clock);
            recv_hold = 0;
         end
         begin
            for (int t = 0; t < 2; t++) random_track(70);
            for (int t = 0; t < 3; t++) random_track(2);
         end
      join
      drain();

      write_cut(24'd1500);
      send_idle_pct = 23;
      recv_idle_pct = 63;
      for (int t = 0; t < 5; t++) random_track($urandom_range(12));
      drain();

      write_cut(24'hFFFFFF);
      send_idle_pct = 63;
      recv_idle_pct = 23;
      for (int t = 0; t < 5; t++) random_track($urandom_range(12));
      drain();

      write_cut(24'd800);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int t = 0; t < 5; t++) random_track($urandom_range(12));
      drain();

      if (board.mismatches == 0 && board.track_results.size() == 0)
         $display("grouped_charge_order_statistics_core_tb: PASS");
      else
         $display("grouped_charge_order_statistics_core_tb: FAIL");
      $finish;
   end
endmodule

// ===== grouped_charge_order_statistics_core.f =====
sv/gcos_pkg.sv
sv/gcos_ram.sv
sv/gcos_front.sv
sv/gcos_fifo.sv
sv/gcos_back.sv
sv/grouped_charge_order_statistics_core.sv
tb/grouped_charge_order_statistics_core_tb.sv
